// File: rtl/salc_pkg.sv
// Shared types, constants and helpers for the set-associative LRU write-back cache lookup.
// No dependencies; used by every module in rtl/.
package salc_pkg;

    localparam int WAYS        = 4;
    localparam int SETS        = 64;
    localparam int TAG_BITS    = 32;
    localparam int AGE_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_BITS    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IDX_BITS    = 6;
    localparam int IN_TAG_BITS = 32;
    localparam int CNT_BITS    = 32;

    typedef logic [SET_BITS-1:0]    set_t;
    typedef logic [AGE_BITS-1:0]    way_idx_t;
    typedef logic [TAG_BITS-1:0]    tag_t;
    typedef logic [IN_TAG_BITS-1:0] ext_tag_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_RETRY = 2'd2
    } outcome_t;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [AGE_BITS-1:0] age;
        tag_t                tag;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic kick;
        logic dirty_kick;
    } count_inc_t;

    typedef struct packed {
        outcome_t outcome;
        ext_tag_t victim_tag;
        cnt_t     hits;
        cnt_t     misses;
        cnt_t     kicks;
        cnt_t     dirty_kicks;
    } result_t;

    // Row contents after reset: nothing valid, highest way most recent.
    function automatic row_t reset_row();
        row_t r;
        for (int w = 0; w < WAYS; w++) begin
            r[w].valid = 1'b0;
            r[w].dirty = 1'b0;
            r[w].age   = AGE_BITS'(WAYS - 1 - w);
            r[w].tag   = '0;
        end
        return r;
    endfunction

    // Set index folded onto the sets present; a small constant table.
    function automatic set_t set_of(logic [IDX_BITS-1:0] idx);
        set_t s;
        s = '0;
        for (int k = 0; k < (1 << IDX_BITS); k++) begin
            if (idx == IDX_BITS'(k)) begin
                s = SET_BITS'(k % SETS);
            end
        end
        return s;
    endfunction

    function automatic tag_t tag_of(ext_tag_t t);
        tag_t r;
        r = '0;
        for (int i = 0; i < TAG_BITS && i < IN_TAG_BITS; i++) begin
            r[i] = t[i];
        end
        return r;
    endfunction

    function automatic ext_tag_t tag_out(tag_t t);
        ext_tag_t r;
        r = '0;
        for (int i = 0; i < TAG_BITS && i < IN_TAG_BITS; i++) begin
            r[i] = t[i];
        end
        return r;
    endfunction

    function automatic cnt_t sat_inc(cnt_t v);
        return (v == '1) ? v : v + cnt_t'(1);
    endfunction

endpackage

// File: rtl/salc_set_store.sv
// Per-set state memory: one row of tags, valid, dirty and ages per set.
// Depends on salc_pkg. Registered read, one write port, per-row written flags.
module salc_set_store (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  salc_pkg::set_t rd_set,
    output salc_pkg::row_t rd_row,
    input  logic           wr_en,
    input  salc_pkg::set_t wr_set,
    input  salc_pkg::row_t wr_row
);
    import salc_pkg::*;

    row_t            mem [SETS];
    logic [SETS-1:0] row_written_reg;
    row_t            rd_data_reg;
    logic            rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_set] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_set];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_written_reg <= '0;
            rd_written_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_written_reg[wr_set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= row_written_reg[rd_set];
            end
        end
    end

    // unwritten row reads as its reset contents
    assign rd_row = rd_written_reg ? rd_data_reg : reset_row();

endmodule

// File: rtl/salc_set_update.sv
// Lookup and update of one set row: hit search, LRU victim, new row, outcome.
// Depends on salc_pkg. Purely combinational.
module salc_set_update (
    input  salc_pkg::row_t       row,
    input  logic                 kind,
    input  salc_pkg::tag_t       tag,
    output salc_pkg::row_t       new_row,
    output salc_pkg::outcome_t   outcome,
    output salc_pkg::ext_tag_t   victim_tag,
    output salc_pkg::count_inc_t inc
);
    import salc_pkg::*;

    logic                hit;
    way_idx_t            hit_way;
    way_idx_t            lru_way;
    way_idx_t            sel;
    logic [AGE_BITS-1:0] sel_age;
    logic                promote;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && row[w].valid && (row[w].tag == tag))
            begin
                hit     = 1'b1;
                hit_way = way_idx_t'(w);
            end
        end

        lru_way = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (row[w].age > row[lru_way].age)
            begin
                lru_way = way_idx_t'(w);
            end
        end

        sel        = hit ? hit_way : lru_way;
        sel_age    = row[sel].age;
        new_row    = row;
        inc        = '0;
        victim_tag = '0;
        promote    = 1'b0;

        if (hit)
        begin
            inc.hit = 1'b1;
            outcome = OUT_HIT;
            if (kind)
            begin
                new_row[sel].dirty = 1'b1;
            end
            promote = 1'b1;
        end
        else
        begin
            inc.kick = row[sel].valid;
            if (row[sel].dirty)
            begin
                // write-back: line dropped, stays least recent
                inc.dirty_kick     = 1'b1;
                new_row[sel].valid = 1'b0;
                new_row[sel].dirty = 1'b0;
                victim_tag         = tag_out(row[sel].tag);
                outcome            = OUT_RETRY;
            end
            else
            begin
                new_row[sel].tag   = tag;
                new_row[sel].valid = 1'b1;
                new_row[sel].dirty = kind;
                inc.miss           = 1'b1;
                outcome            = OUT_FILL;
                promote            = 1'b1;
            end
        end

        if (promote)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (row[w].age < sel_age)
                begin
                    new_row[w].age = row[w].age + 1'b1;
                end
            end
            new_row[sel].age = '0;
        end
    end

endmodule

// File: rtl/set_assoc_lru_writeback_cache_lookup.sv
// Set-associative write-back cache lookup with true LRU replacement: top level.
// Depends on salc_pkg, salc_set_store and salc_set_update.
//
// Each access word (kind, line_tag, set_index) gives one result word: outcome
// (hit, miss filled, or dirty victim evicted so the access must be retried),
// the evicted tag on a retry, and the four saturating counters as they stand
// after the access. In the accept cycle the set's row is read from the state
// memory, in the next cycle the row is updated and written back and the result
// registered. No new access is taken until that read-modify-write of the state
// memory is done. A result waiting on the output does not hold up the next access:
// a one-word skid register takes the following result, and access_ready is held
// low during a lookup and while the skid register is full. There is no clearing
// pass after reset: each memory row carries a written flag, and an unwritten row
// reads as nothing valid with the highest way most recent.
module set_assoc_lru_writeback_cache_lookup (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   access_valid,
    output logic                   access_ready,
    input  logic                   kind,
    input  logic [31:0]            line_tag,
    input  logic [5:0]             set_index,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [1:0]             outcome,
    output logic [31:0]            victim_tag,
    output logic [31:0]            hit_count,
    output logic [31:0]            miss_count,
    output logic [31:0]            kickout_count,
    output logic [31:0]            dirty_kickout_count
);
    import salc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic       kind_reg;
    tag_t       tag_reg;
    set_t       set_reg;

    cnt_t       hits_reg, hits_next;
    cnt_t       misses_reg, misses_next;
    cnt_t       kicks_reg, kicks_next;
    cnt_t       dkicks_reg, dkicks_next;

    result_t    out_reg;
    logic       out_valid_reg;
    result_t    skid_reg;
    logic       skid_valid_reg;

    logic       accept;
    logic       take;
    logic       look;
    row_t       rd_row;
    row_t       new_row;
    outcome_t   upd_outcome;
    ext_tag_t   upd_victim;
    count_inc_t inc;
    result_t    res;

    assign access_ready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign accept       = access_valid && access_ready;
    assign look         = (state_reg == ST_LOOK);
    assign take         = out_valid_reg && result_ready;

    salc_set_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_set (set_of(set_index)),
        .rd_row (rd_row),
        .wr_en  (look),
        .wr_set (set_reg),
        .wr_row (new_row)
    );

    salc_set_update u_update (
        .row        (rd_row),
        .kind       (kind_reg),
        .tag        (tag_reg),
        .new_row    (new_row),
        .outcome    (upd_outcome),
        .victim_tag (upd_victim),
        .inc        (inc)
    );

    // counters as they stand after this access
    always_comb
    begin
        hits_next   = inc.hit        ? sat_inc(hits_reg)   : hits_reg;
        misses_next = inc.miss       ? sat_inc(misses_reg) : misses_reg;
        kicks_next  = inc.kick       ? sat_inc(kicks_reg)  : kicks_reg;
        dkicks_next = inc.dirty_kick ? sat_inc(dkicks_reg) : dkicks_reg;

        res.outcome     = upd_outcome;
        res.victim_tag  = upd_victim;
        res.hits        = hits_next;
        res.misses      = misses_next;
        res.kicks       = kicks_next;
        res.dirty_kicks = dkicks_next;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_LOOK : ST_IDLE;
            ST_LOOK: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // held access word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            tag_reg  <= tag_of(line_tag);
            set_reg  <= set_of(set_index);
        end
    end

    // result payload: skid is always empty while a lookup is in flight
    always_ff @(posedge clk)
    begin
        if (look)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hits_reg       <= '0;
            misses_reg     <= '0;
            kicks_reg      <= '0;
            dkicks_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (look)
            begin
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                kicks_reg  <= kicks_next;
                dkicks_reg <= dkicks_next;
                if (!out_valid_reg || take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid        = out_valid_reg;
    assign outcome             = out_reg.outcome;
    assign victim_tag          = out_reg.victim_tag;
    assign hit_count           = out_reg.hits;
    assign miss_count          = out_reg.misses;
    assign kickout_count       = out_reg.kicks;
    assign dirty_kickout_count = out_reg.dirty_kicks;

endmodule

// File: rtl/salc_checker.sv
// Port-level checks for the cache lookup, bound to the top level.
// Depends on salc_pkg; attaches to set_assoc_lru_writeback_cache_lookup.
module salc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        access_valid,
    input logic        access_ready,
    input logic        kind,
    input logic [31:0] line_tag,
    input logic [5:0]  set_index,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  outcome,
    input logic [31:0] victim_tag,
    input logic [31:0] hit_count,
    input logic [31:0] miss_count,
    input logic [31:0] kickout_count,
    input logic [31:0] dirty_kickout_count
);
    import salc_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(outcome)
        && $stable(victim_tag) && $stable(hit_count))
        else $error("stalled result word changed");

    // one access in flight: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        access_valid && access_ready |=> !access_ready)
        else $error("access accepted during lookup");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (outcome != OUT_RETRY) |-> victim_tag == '0)
        else $error("victim tag set without retry");

    a_count_seen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((outcome != OUT_HIT) || (hit_count != '0))
        && ((outcome != OUT_FILL) || (miss_count != '0))
        && ((outcome != OUT_RETRY) || (dirty_kickout_count != '0)))
        else $error("outcome not reflected in its counter");

    a_dirty_le_kick: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> dirty_kickout_count <= kickout_count)
        else $error("dirty kickouts exceed kickouts");

endmodule

bind set_assoc_lru_writeback_cache_lookup salc_checker u_salc_checker (.*);
